// File: rtl/core/pdj_pkg.sv
// ----------------------------------------------------------------------------
// pdj_pkg
// Shared widths, register codes, coefficient bundle, arctangent table and
// saturation helper for the pendulum dynamics and Jacobian pipeline.
// ----------------------------------------------------------------------------
package pdj_pkg;

   // fixed point format and pipeline sizing
   localparam int FRAC_BITS     = 16;
   localparam int CORDIC_STAGES = 16;

   localparam int REG_W      = 31;
   localparam int WORD_W     = 32;
   localparam int PROD_W     = 2 * REG_W;
   localparam int WIDE_W     = 3 * REG_W;
   localparam int NUM_W      = WIDE_W + FRAC_BITS + 3;
   localparam int QUO_W      = 32;
   localparam int DIV_STAGES = QUO_W + 1;
   localparam int CORDIC_W   = 34;
   localparam int TRIG_W     = FRAC_BITS + 2;
   localparam int MAG_W      = FRAC_BITS + 1;

   // 2^32 / (2*pi), rounded
   localparam logic [REG_W-1:0] TURNS_PER_RAD = 31'd683565276;
   // cordic gain compensation in Q30
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032875;

   // register reset values
   localparam logic [REG_W-1:0] MASS_RESET     = 31'd65536;
   localparam logic [REG_W-1:0] GRAVITY_RESET  = 31'd642908;
   localparam logic [REG_W-1:0] ROD_RESET      = 31'd65536;
   localparam logic [REG_W-1:0] FRICTION_RESET = 31'd0;

   typedef enum logic [1:0] {
      CSR_MASS,
      CSR_GRAVITY,
      CSR_ROD_LENGTH,
      CSR_FRICTION
   } csr_index_type;

   // configuration and the products derived from it
   typedef struct packed {
      logic [REG_W-1:0]  mass;
      logic [REG_W-1:0]  gravity;
      logic [REG_W-1:0]  rod_length;
      logic [REG_W-1:0]  friction;
      logic [WIDE_W-1:0] inertia;
      logic [WIDE_W-1:0] mgl;
      logic              zero_inertia;
   } coef_type;

   // fields that ride along with the angle through the cordic
   typedef struct packed {
      logic signed [WORD_W-1:0] angle_rate;
      logic signed [WORD_W-1:0] torque;
   } side_type;

   // arctangent of 2^-i in 2^-32 turns
   function automatic logic [29:0] atan_turns(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0:    v = 30'd536870912;
         5'd1:    v = 30'd316933406;
         5'd2:    v = 30'd167458907;
         5'd3:    v = 30'd85004756;
         5'd4:    v = 30'd42667331;
         5'd5:    v = 30'd21354465;
         5'd6:    v = 30'd10680862;
         5'd7:    v = 30'd5340245;
         5'd8:    v = 30'd2670163;
         5'd9:    v = 30'd1335087;
         5'd10:   v = 30'd667544;
         5'd11:   v = 30'd333772;
         5'd12:   v = 30'd166886;
         5'd13:   v = 30'd83443;
         5'd14:   v = 30'd41722;
         5'd15:   v = 30'd20861;
         5'd16:   v = 30'd10430;
         5'd17:   v = 30'd5215;
         5'd18:   v = 30'd2608;
         5'd19:   v = 30'd1304;
         5'd20:   v = 30'd652;
         5'd21:   v = 30'd326;
         5'd22:   v = 30'd163;
         5'd23:   v = 30'd81;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   // signed saturation of a quotient magnitude, overflow flag in the top bit
   function automatic logic [WORD_W:0] sat_word(input logic [QUO_W-1:0] q,
                                                input logic big,
                                                input logic neg);
      logic [QUO_W:0]    limit;
      logic [WORD_W-1:0] v;
      logic              o;
      limit = neg ? 33'h080000000 : 33'h07fffffff;
      if (big || ({1'b0, q} > limit)) begin
         o = 1'b1;
         v = neg ? 32'h80000000 : 32'h7fffffff;
      end else begin
         o = 1'b0;
         v = neg ? (~q + 32'd1) : q;
      end
      return {o, v};
   endfunction

endpackage

// File: rtl/core/pdj_coef.sv
// ----------------------------------------------------------------------------
// pdj_coef
// Configuration registers and the inertia and m*g*l products, rebuilt from
// the registers every cycle through a three stage multiplier chain.
// ----------------------------------------------------------------------------
module pdj_coef (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [pdj_pkg::REG_W-1:0]  csr_wdata,
   output pdj_pkg::coef_type          coef
);
   import pdj_pkg::*;

   logic [REG_W-1:0]  mass_ff, gravity_ff, rod_ff, friction_ff;
   logic [PROD_W-1:0] mr_ff, mg_ff;
   logic [PROD_W-1:0] mr_hi_ff, mr_lo_ff, mg_hi_ff, mg_lo_ff;
   logic [WIDE_W-1:0] inertia_ff, mgl_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mass_ff     <= MASS_RESET;
         gravity_ff  <= GRAVITY_RESET;
         rod_ff      <= ROD_RESET;
         friction_ff <= FRICTION_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MASS:       mass_ff     <= csr_wdata;
            CSR_GRAVITY:    gravity_ff  <= csr_wdata;
            CSR_ROD_LENGTH: rod_ff      <= csr_wdata;
            CSR_FRICTION:   friction_ff <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // m*l*l and m*g*l, split so no product is wider than 31 by 31
   always_ff @(posedge clock) begin
      mr_ff      <= mass_ff * rod_ff;
      mg_ff      <= mass_ff * gravity_ff;
      mr_hi_ff   <= mr_ff[PROD_W-1:REG_W] * rod_ff;
      mr_lo_ff   <= mr_ff[REG_W-1:0] * rod_ff;
      mg_hi_ff   <= mg_ff[PROD_W-1:REG_W] * rod_ff;
      mg_lo_ff   <= mg_ff[REG_W-1:0] * rod_ff;
      inertia_ff <= (WIDE_W'(mr_hi_ff) << REG_W) + WIDE_W'(mr_lo_ff);
      mgl_ff     <= (WIDE_W'(mg_hi_ff) << REG_W) + WIDE_W'(mg_lo_ff);
   end

   assign coef.mass         = mass_ff;
   assign coef.gravity      = gravity_ff;
   assign coef.rod_length   = rod_ff;
   assign coef.friction     = friction_ff;
   assign coef.inertia      = inertia_ff;
   assign coef.mgl          = mgl_ff;
   assign coef.zero_inertia = (mass_ff == '0) || (rod_ff == '0);

endmodule

// File: rtl/core/pdj_cordic.sv
// ----------------------------------------------------------------------------
// pdj_cordic
// Angle to phase in turns, fold into a half turn, one rotation per stage,
// then rounding of cosine and sine to the output fraction width.
// ----------------------------------------------------------------------------
module pdj_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [pdj_pkg::WORD_W-1:0] angle,
   input  pdj_pkg::side_type                 side_in,
   output logic                              out_valid,
   output logic signed [pdj_pkg::TRIG_W-1:0] cos_out,
   output logic signed [pdj_pkg::TRIG_W-1:0] sin_out,
   output pdj_pkg::side_type                 side_out
);
   import pdj_pkg::*;

   localparam logic signed [WORD_W-1:0]   QUARTER  = 32'sh40000000;
   localparam logic signed [CORDIC_W-1:0] HALF     = 34'sh080000000;
   localparam logic signed [CORDIC_W-1:0] HALF_LSB = CORDIC_W'(1) << (29 - FRAC_BITS);
   localparam logic signed [CORDIC_W-1:0] ONE      = CORDIC_W'(1) << FRAC_BITS;

   function automatic logic signed [TRIG_W-1:0] to_frac(
      input logic signed [CORDIC_W-1:0] v);
      logic signed [CORDIC_W-1:0] r;
      r = (v + HALF_LSB) >>> (30 - FRAC_BITS);
      if (r > ONE) begin
         r = ONE;
      end else if (r < -ONE) begin
         r = -ONE;
      end
      return r[TRIG_W-1:0];
   endfunction

   logic signed [WORD_W+REG_W-1:0] prod;
   logic                           valid_a_ff;
   logic [WORD_W-1:0]              phase_ff;
   side_type                       side_a_ff;

   logic signed [WORD_W-1:0]       p;
   logic signed [CORDIC_W-1:0]     z_in;
   logic                           flip_in;

   logic                           v_ff    [CORDIC_STAGES+1];
   logic signed [CORDIC_W-1:0]     x_ff    [CORDIC_STAGES+1];
   logic signed [CORDIC_W-1:0]     y_ff    [CORDIC_STAGES+1];
   logic signed [CORDIC_W-1:0]     z_ff    [CORDIC_STAGES+1];
   logic                           flip_ff [CORDIC_STAGES+1];
   side_type                       side_ff [CORDIC_STAGES+1];

   logic                           out_valid_ff;
   logic signed [TRIG_W-1:0]       cos_ff, sin_ff;
   side_type                       side_out_ff;
   logic signed [CORDIC_W-1:0]     xf, yf;

   // angle times turns per radian, keep the phase bits
   assign prod = angle * $signed({1'b0, TURNS_PER_RAD});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
      phase_ff  <= prod[FRAC_BITS+WORD_W-1:FRAC_BITS];
      side_a_ff <= side_in;
   end

   // fold into [-1/4, 1/4] turn
   always_comb begin
      p       = $signed(phase_ff);
      z_in    = CORDIC_W'(p);
      flip_in = 1'b0;
      if (p > QUARTER) begin
         z_in    = CORDIC_W'(p) - HALF;
         flip_in = 1'b1;
      end else if (p < -QUARTER) begin
         z_in    = CORDIC_W'(p) + HALF;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= valid_a_ff;
      end
      x_ff[0]    <= CORDIC_GAIN;
      y_ff[0]    <= '0;
      z_ff[0]    <= z_in;
      flip_ff[0] <= flip_in;
      side_ff[0] <= side_a_ff;
   end

   // rotation stages
   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
      localparam logic signed [CORDIC_W-1:0] ATAN = CORDIC_W'(atan_turns(5'(k)));
      logic signed [CORDIC_W-1:0] dx, dy;
      assign dx = y_ff[k] >>> k;
      assign dy = x_ff[k] >>> k;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else begin
            v_ff[k+1] <= v_ff[k];
         end
         if (!z_ff[k][CORDIC_W-1]) begin
            x_ff[k+1] <= x_ff[k] - dx;
            y_ff[k+1] <= y_ff[k] + dy;
            z_ff[k+1] <= z_ff[k] - ATAN;
         end else begin
            x_ff[k+1] <= x_ff[k] + dx;
            y_ff[k+1] <= y_ff[k] - dy;
            z_ff[k+1] <= z_ff[k] + ATAN;
         end
         flip_ff[k+1] <= flip_ff[k];
         side_ff[k+1] <= side_ff[k];
      end
   end

   // undo the fold, round and clamp
   assign xf = flip_ff[CORDIC_STAGES] ? -x_ff[CORDIC_STAGES] : x_ff[CORDIC_STAGES];
   assign yf = flip_ff[CORDIC_STAGES] ? -y_ff[CORDIC_STAGES] : y_ff[CORDIC_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= v_ff[CORDIC_STAGES];
      end
      cos_ff      <= to_frac(xf);
      sin_ff      <= to_frac(yf);
      side_out_ff <= side_ff[CORDIC_STAGES];
   end

   assign out_valid = out_valid_ff;
   assign cos_out   = cos_ff;
   assign sin_out   = sin_ff;
   assign side_out  = side_out_ff;

endmodule

// File: rtl/core/pdj_div.sv
// ----------------------------------------------------------------------------
// pdj_div
// Pipelined restoring divider, one quotient bit per stage. Gives a 32-bit
// quotient and a flag when the true quotient does not fit in 32 bits.
// ----------------------------------------------------------------------------
module pdj_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [pdj_pkg::NUM_W-1:0]   num,
   input  logic [pdj_pkg::WIDE_W-1:0]  den,
   output logic                        out_valid,
   output logic [pdj_pkg::QUO_W-1:0]   quo,
   output logic                        big
);
   import pdj_pkg::*;

   localparam int CMP_W = WIDE_W + QUO_W;

   logic              v_ff   [QUO_W+1];
   logic [NUM_W-1:0]  r_ff   [QUO_W+1];
   logic [WIDE_W-1:0] d_ff   [QUO_W+1];
   logic [QUO_W-1:0]  q_ff   [QUO_W+1];
   logic              big_ff [QUO_W+1];
   logic              dz_ff  [QUO_W+1];

   logic              dz_in, big_in;

   // range check: quotient fits only if num < den * 2^32
   assign dz_in  = (den == '0);
   assign big_in = dz_in ? (num != '0)
                         : (CMP_W'(num) >= (CMP_W'(den) << QUO_W));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      r_ff[0]   <= num;
      d_ff[0]   <= den;
      q_ff[0]   <= '0;
      big_ff[0] <= big_in;
      dz_ff[0]  <= dz_in;
   end

   // one quotient bit per stage, most significant first
   for (genvar j = 0; j < QUO_W; j++) begin : g_bit
      logic [CMP_W-1:0] shifted;
      logic             ge;
      assign shifted = CMP_W'(d_ff[j]) << (QUO_W - 1 - j);
      assign ge      = CMP_W'(r_ff[j]) >= shifted;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j+1] <= 1'b0;
         end else begin
            v_ff[j+1] <= v_ff[j];
         end
         r_ff[j+1]   <= ge ? (r_ff[j] - shifted[NUM_W-1:0]) : r_ff[j];
         d_ff[j+1]   <= d_ff[j];
         q_ff[j+1]   <= {q_ff[j][QUO_W-2:0], ge};
         big_ff[j+1] <= big_ff[j];
         dz_ff[j+1]  <= dz_ff[j];
      end
   end

   assign out_valid = v_ff[QUO_W];
   assign quo       = dz_ff[QUO_W] ? '0 : q_ff[QUO_W];
   assign big       = big_ff[QUO_W];

endmodule

// File: rtl/core/pendulum_dynamics_jacobian.sv
// ----------------------------------------------------------------------------
// pendulum_dynamics_jacobian
// A word accepted on start passes through the cordic, the numerator stages,
// the dividers and the output register before it appears on rsp_*.
// Throughput: one word per cycle, busy stays low; the result is a one-cycle
// strobe on rsp_valid. Synchronous reset clears valid bits and restores the
// register defaults; derived coefficients settle after a write through pdj_coef.
// ----------------------------------------------------------------------------
module pendulum_dynamics_jacobian (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [pdj_pkg::WORD_W-1:0] req_angle,
   input  logic signed [pdj_pkg::WORD_W-1:0] req_angle_rate,
   input  logic signed [pdj_pkg::WORD_W-1:0] req_torque,
   output logic                              rsp_valid,
   output logic signed [pdj_pkg::WORD_W-1:0] rsp_angle_deriv,
   output logic signed [pdj_pkg::WORD_W-1:0] rsp_rate_deriv,
   output logic signed [pdj_pkg::WORD_W-1:0] rsp_jac_angle,
   output logic signed [pdj_pkg::WORD_W-1:0] rsp_jac_rate,
   output logic signed [pdj_pkg::WORD_W-1:0] rsp_control_gain,
   output logic                              rsp_overflow,
   input  logic                              csr_we,
   input  logic [1:0]                        csr_index,
   input  logic [pdj_pkg::REG_W-1:0]         csr_wdata
);
   import pdj_pkg::*;

   localparam logic [NUM_W-1:0] GAIN_NUM = NUM_W'(1) << (4 * FRAC_BITS);

   typedef struct packed {
      logic signed [WORD_W-1:0] rate;
      logic                     nneg;
      logic                     cpos;
   } tail_type;

   coef_type                 coef;
   side_type                 side_in, side_c;
   logic                     accept;
   logic                     c_valid;
   logic signed [TRIG_W-1:0] cos_c, sin_c;

   logic [MAG_W-1:0]         s_mag, c_mag;
   logic [WORD_W-1:0]        rate_mag, tq_mag;

   // numerator stages
   logic                        p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff;
   logic [REG_W+MAG_W-1:0]      p1_tg0_ff, p1_tg1_ff, p1_tg2_ff, p1_gc_ff;
   logic [REG_W+WORD_W-1:0]     p1_tb_ff;
   logic [WORD_W-1:0]           p1_tu_ff;
   logic                        p1_tg_neg_ff, p1_tb_neg_ff, p1_tu_neg_ff, p1_cpos_ff;
   logic signed [WORD_W-1:0]    p1_rate_ff;

   logic [NUM_W-1:0]            p2_tg_ff, p2_tu_ff, p2_tb_ff;
   logic                        p2_tg_neg_ff, p2_cpos_ff;
   logic [REG_W+MAG_W-1:0]      p2_gc_ff;
   logic signed [WORD_W-1:0]    p2_rate_ff;

   logic [NUM_W-1:0]            p3_num_ff;
   logic                        p3_cpos_ff;
   logic [REG_W+MAG_W-1:0]      p3_gc_ff;
   logic signed [WORD_W-1:0]    p3_rate_ff;

   logic [NUM_W-1:0]            p4_nmag_ff;
   logic                        p4_nneg_ff, p4_cpos_ff;
   logic [REG_W+MAG_W-1:0]      p4_gc_ff;
   logic signed [WORD_W-1:0]    p4_rate_ff;

   logic [NUM_W-1:0]            tu_in, tb_in;

   // divider outputs and sidebands
   logic                        dv_rate, dv_ang, dv_fric, dv_gain;
   logic [QUO_W-1:0]            q_rate, q_ang, q_fric, q_gain;
   logic                        b_rate, b_ang, b_fric, b_gain;
   tail_type                    tail_ff [DIV_STAGES];

   logic [WORD_W:0]             s_rate, s_ang, s_fric, s_gain;
   logic                        rsp_valid_ff, overflow_ff;
   logic signed [WORD_W-1:0]    angle_deriv_ff, rate_deriv_ff, jac_angle_ff;
   logic signed [WORD_W-1:0]    jac_rate_ff, control_gain_ff;

   // every cycle can take a word
   assign busy   = 1'b0;
   assign accept = start && !busy;

   pdj_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .coef      (coef)
   );

   assign side_in.angle_rate = req_angle_rate;
   assign side_in.torque     = req_torque;

   pdj_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .angle     (req_angle),
      .side_in   (side_in),
      .out_valid (c_valid),
      .cos_out   (cos_c),
      .sin_out   (sin_c),
      .side_out  (side_c)
   );

   // magnitudes of the signed operands
   assign s_mag    = sin_c[TRIG_W-1] ? MAG_W'(-sin_c) : MAG_W'(sin_c);
   assign c_mag    = cos_c[TRIG_W-1] ? MAG_W'(-cos_c) : MAG_W'(cos_c);
   assign rate_mag = side_c.angle_rate[WORD_W-1] ? -side_c.angle_rate
                                                 : side_c.angle_rate;
   assign tq_mag   = side_c.torque[WORD_W-1] ? -side_c.torque : side_c.torque;

   // stage 1: partial products
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= c_valid;
      end
      p1_tg0_ff    <= coef.mgl[REG_W-1:0] * s_mag;
      p1_tg1_ff    <= coef.mgl[PROD_W-1:REG_W] * s_mag;
      p1_tg2_ff    <= coef.mgl[WIDE_W-1:PROD_W] * s_mag;
      p1_gc_ff     <= coef.gravity * c_mag;
      p1_tb_ff     <= coef.friction * rate_mag;
      p1_tu_ff     <= tq_mag;
      p1_tg_neg_ff <= !sin_c[TRIG_W-1] && (sin_c != '0);
      p1_tb_neg_ff <= !side_c.angle_rate[WORD_W-1] && (side_c.angle_rate != '0);
      p1_tu_neg_ff <= side_c.torque[WORD_W-1];
      p1_cpos_ff   <= !cos_c[TRIG_W-1] && (cos_c != '0);
      p1_rate_ff   <= side_c.angle_rate;
   end

   // stage 2: gravity term magnitude, signed torque and friction terms
   assign tu_in = NUM_W'(p1_tu_ff) << (3 * FRAC_BITS);
   assign tb_in = NUM_W'(p1_tb_ff) << (2 * FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
      p2_tg_ff     <= NUM_W'(p1_tg0_ff) + (NUM_W'(p1_tg1_ff) << REG_W)
                      + (NUM_W'(p1_tg2_ff) << PROD_W);
      p2_tu_ff     <= p1_tu_neg_ff ? -tu_in : tu_in;
      p2_tb_ff     <= p1_tb_neg_ff ? -tb_in : tb_in;
      p2_tg_neg_ff <= p1_tg_neg_ff;
      p2_cpos_ff   <= p1_cpos_ff;
      p2_gc_ff     <= p1_gc_ff;
      p2_rate_ff   <= p1_rate_ff;
   end

   // stage 3: signed numerator
   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= p2_valid_ff;
      end
      p3_num_ff  <= p2_tg_neg_ff ? (p2_tu_ff + p2_tb_ff - p2_tg_ff)
                                 : (p2_tu_ff + p2_tb_ff + p2_tg_ff);
      p3_cpos_ff <= p2_cpos_ff;
      p3_gc_ff   <= p2_gc_ff;
      p3_rate_ff <= p2_rate_ff;
   end

   // stage 4: sign and magnitude
   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else begin
         p4_valid_ff <= p3_valid_ff;
      end
      p4_nneg_ff <= p3_num_ff[NUM_W-1];
      p4_nmag_ff <= p3_num_ff[NUM_W-1] ? -p3_num_ff : p3_num_ff;
      p4_cpos_ff <= p3_cpos_ff;
      p4_gc_ff   <= p3_gc_ff;
      p4_rate_ff <= p3_rate_ff;
   end

   // four dividers in lockstep
   pdj_div u_div_rate (
      .clock (clock), .reset (reset), .in_valid (p4_valid_ff),
      .num (p4_nmag_ff), .den (coef.inertia),
      .out_valid (dv_rate), .quo (q_rate), .big (b_rate)
   );

   pdj_div u_div_ang (
      .clock (clock), .reset (reset), .in_valid (p4_valid_ff),
      .num (NUM_W'(p4_gc_ff)), .den (WIDE_W'(coef.rod_length)),
      .out_valid (dv_ang), .quo (q_ang), .big (b_ang)
   );

   pdj_div u_div_fric (
      .clock (clock), .reset (reset), .in_valid (p4_valid_ff),
      .num (NUM_W'(coef.friction) << (3 * FRAC_BITS)), .den (coef.inertia),
      .out_valid (dv_fric), .quo (q_fric), .big (b_fric)
   );

   pdj_div u_div_gain (
      .clock (clock), .reset (reset), .in_valid (p4_valid_ff),
      .num (GAIN_NUM), .den (coef.inertia),
      .out_valid (dv_gain), .quo (q_gain), .big (b_gain)
   );

   // sidebands matched to the divider depth
   always_ff @(posedge clock) begin
      tail_ff[0].rate <= p4_rate_ff;
      tail_ff[0].nneg <= p4_nneg_ff;
      tail_ff[0].cpos <= p4_cpos_ff;
      for (int i = 1; i < DIV_STAGES; i++) begin
         tail_ff[i] <= tail_ff[i-1];
      end
   end

   // saturation and output register
   assign s_rate = sat_word(q_rate, b_rate, tail_ff[DIV_STAGES-1].nneg);
   assign s_ang  = sat_word(q_ang,  b_ang,  tail_ff[DIV_STAGES-1].cpos);
   assign s_fric = sat_word(q_fric, b_fric, 1'b1);
   assign s_gain = sat_word(q_gain, b_gain, 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_rate && dv_ang && dv_fric && dv_gain;
      end
      angle_deriv_ff  <= tail_ff[DIV_STAGES-1].rate;
      rate_deriv_ff   <= s_rate[WORD_W-1:0];
      jac_angle_ff    <= s_ang[WORD_W-1:0];
      jac_rate_ff     <= s_fric[WORD_W-1:0];
      control_gain_ff <= s_gain[WORD_W-1:0];
      overflow_ff     <= s_rate[WORD_W] || s_ang[WORD_W] || s_fric[WORD_W]
                         || s_gain[WORD_W] || coef.zero_inertia;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_angle_deriv  = angle_deriv_ff;
   assign rsp_rate_deriv   = rate_deriv_ff;
   assign rsp_jac_angle    = jac_angle_ff;
   assign rsp_jac_rate     = jac_rate_ff;
   assign rsp_control_gain = control_gain_ff;
   assign rsp_overflow     = overflow_ff;

endmodule
